// ----- rtl/fsk_pkg.sv -----
// Shared types and constants for the FSK frame bit serializer.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package fsk_pkg;

  // Input word opcodes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_e;

  // Configuration register index port width and register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_MARK_STEP  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_STEP = 4'd1;

  // Reset values of the tone step registers
  localparam logic [7:0] MarkStepReset  = 8'd6;
  localparam logic [7:0] SpaceStepReset = 8'd11;

  // Frame layout: start at 0, data at 1..8 MSB first, parity at 9, stop at 10
  localparam logic [3:0] FrameStartIdx  = 4'd0;
  localparam logic [3:0] FrameParityIdx = 4'd9;
  localparam logic [3:0] FrameStopIdx   = 4'd10;
  localparam logic [3:0] DataBits       = 4'd8;

  // FIFO status toward the control logic
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // One result word
  typedef struct packed {
    logic [7:0] step_value;
    logic       bit_sent;
    logic       frame_end;
    logic       push_dropped;
    logic       busy_res;
  } result_t;

endpackage

// ----- rtl/fsk_if.sv -----
// Valid/ready channel interfaces: input words, result words, register writes.
// Depends on fsk_pkg for the register index width.
`timescale 1ns / 1ps

interface fsk_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface fsk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] step_value;
  logic       bit_sent;
  logic       frame_end;
  logic       push_dropped;
  logic       busy_res;

  modport source (output valid, output step_value, output bit_sent, output frame_end,
                  output push_dropped, output busy_res, input ready);
  modport sink (input valid, input step_value, input bit_sent, input frame_end,
                input push_dropped, input busy_res, output ready);
endinterface

interface fsk_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fsk_pkg::CfgIdxW-1:0]   index;
  logic [7:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/fsk_frame_bit_serializer_top.sv -----
// Top level of the FSK frame bit serializer: FIFO, framer, result queue and
// tone step registers. Depends on fsk_pkg, fsk_if, fsk_fifo, fsk_framer, fsk_res_buf.
`timescale 1ns / 1ps

// Each input word is a push (queue one byte) or a bit-time tick, and yields exactly
// one result word. The block takes one input word per clock: the FIFO update and
// the framer step are a single register-to-register pass, and the FIFO read for a
// new frame is registered at the tick that sends the start bit, so the data bits
// are ready from the following tick on. A two-entry result queue lets a new word in
// while one result waits downstream; input ready drops only when both entries are
// full. A push into a full FIFO is discarded and flagged. The FIFO memory needs no
// clearing after reset, so input is accepted from the first cycle. Register writes
// are always accepted and take effect from the next emitted bit.
module fsk_frame_bit_serializer_top #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsk_in_if.sink     in_i,
  fsk_cfg_if.sink    cfg_i,
  fsk_out_if.source  out_o
);
  import fsk_pkg::*;

  logic       [7:0] mark_q, space_q;
  logic             accept, push, push_ok, tick, load;
  logic             buf_ready, sending;
  logic       [7:0] shift_word;
  fifo_stat_t       fstat;
  result_t          frm_res, res;

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= MarkStepReset;
      space_q <= SpaceStepReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MARK_STEP:  mark_q  <= cfg_i.data;
        CFG_SPACE_STEP: space_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Decode the accepted input word
  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && (op_e'(in_i.opcode) == OP_PUSH);
  assign tick       = accept && (op_e'(in_i.opcode) == OP_TICK);
  assign push_ok    = push && !fstat.full;
  assign load       = tick && !sending && !fstat.empty;

  fsk_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_ok),
    .data_i    (in_i.data_byte),
    .pop_i     (load),
    .rd_data_o (shift_word),
    .stat_o    (fstat)
  );

  fsk_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .load_i       (load),
    .shift_word_i (shift_word),
    .mark_step_i  (mark_q),
    .space_step_i (space_q),
    .sending_o    (sending),
    .res_o        (frm_res)
  );

  // Merge the drop flag into the framer result
  always_comb begin
    res              = frm_res;
    res.push_dropped = push && fstat.full;
  end

  fsk_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept),
    .wr_data_i  (res),
    .wr_ready_o (buf_ready),
    .out_o      (out_o)
  );

  // A stop bit is always an emitted bit
  a_end_is_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.frame_end |-> res.bit_sent && !res.busy_res)
    else $error("frame end without an emitted bit");

  // A frame load sends the start bit on the space step and leaves the block busy
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> sending)
    else $error("frame load did not start sending");

  // Input stalls only while results wait downstream
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no pending result");

  // A full FIFO is never empty
  a_fifo_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fstat.full && fstat.empty))
    else $error("FIFO flags both set");

endmodule

// ----- rtl/fsk_fifo.sv -----
// Byte FIFO: memory array with head/tail pointers and a fill count.
// The read word is registered at pop and doubles as the frame shift word.
// Depends on fsk_pkg.
`timescale 1ns / 1ps

module fsk_fifo #(
  parameter int unsigned Depth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          data_i,
  input  logic                pop_i,
  output logic [7:0]          rd_data_o,
  output fsk_pkg::fifo_stat_t stat_o
);
  import fsk_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [7:0]      mem_q [Depth];
  logic [7:0]      rd_q;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // Advance pointers with wrap at the configured depth
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
    end
    if (pop_i) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= data_i;
    end
    if (pop_i) begin
      rd_q <= mem_q[head_q];
    end
  end

  assign rd_data_o    = rd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);

endmodule

// ----- rtl/fsk_framer.sv -----
// 8E1 frame serializer: bit counter, parity accumulator and held tone step.
// Takes the shift word from the FIFO read register. Depends on fsk_pkg.
`timescale 1ns / 1ps

module fsk_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 load_i,
  input  logic [7:0]           shift_word_i,
  input  logic [7:0]           mark_step_i,
  input  logic [7:0]           space_step_i,
  output logic                 sending_o,
  output fsk_pkg::result_t     res_o
);
  import fsk_pkg::*;

  logic       sending_q, sending_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  logic       parity_q, parity_d;
  logic [7:0] held_q, held_d;

  logic       active;
  logic [3:0] idx;
  logic       par;
  logic [2:0] sel;
  logic       bit_val;
  logic       frame_end;

  // Pick the frame bit for this tick
  always_comb begin
    active    = tick_i && (sending_q || load_i);
    idx       = load_i ? FrameStartIdx : bit_idx_q;
    par       = load_i ? 1'b0 : parity_q;
    sel       = 3'(DataBits - idx);
    frame_end = 1'b0;
    parity_d  = par;
    if (idx == FrameStartIdx) begin
      bit_val = 1'b0;
    end else if (idx == FrameParityIdx) begin
      bit_val = par;
    end else if (idx >= FrameStopIdx) begin
      bit_val   = 1'b1;
      frame_end = 1'b1;
    end else begin
      bit_val  = shift_word_i[sel];
      parity_d = par ^ bit_val;
    end
  end

  // Next state: hold unless a bit goes out
  always_comb begin
    sending_d = sending_q;
    bit_idx_d = bit_idx_q;
    held_d    = held_q;
    if (active) begin
      sending_d = !frame_end;
      bit_idx_d = idx + 1'b1;
      held_d    = bit_val ? mark_step_i : space_step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      bit_idx_q <= '0;
      parity_q  <= 1'b0;
      held_q    <= MarkStepReset;
    end else begin
      sending_q <= sending_d;
      bit_idx_q <= bit_idx_d;
      if (active) begin
        parity_q <= parity_d;
      end
      held_q <= held_d;
    end
  end

  assign sending_o          = sending_q;
  assign res_o.step_value   = held_d;
  assign res_o.bit_sent     = active;
  assign res_o.frame_end    = active && frame_end;
  assign res_o.push_dropped = 1'b0;
  assign res_o.busy_res     = sending_d;

endmodule

// ----- rtl/fsk_res_buf.sv -----
// Two-entry result queue between the core and the output channel.
// Lets a new input word in while one result waits. Depends on fsk_pkg.
`timescale 1ns / 1ps

module fsk_res_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  fsk_pkg::result_t  wr_data_i,
  output logic              wr_ready_o,
  fsk_out_if.source         out_o
);
  import fsk_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       rd;
  result_t    head;

  assign rd         = out_o.valid && out_o.ready;
  assign wr_ready_o = (count_q != 2'd2);
  assign head       = slot_q[rd_ptr_q];

  // Store the result word
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Track fill and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_i && !rd) begin
        count_q <= count_q + 1'b1;
      end else if (rd && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign out_o.valid        = (count_q != '0);
  assign out_o.step_value   = head.step_value;
  assign out_o.bit_sent     = head.bit_sent;
  assign out_o.frame_end    = head.frame_end;
  assign out_o.push_dropped = head.push_dropped;
  assign out_o.busy_res     = head.busy_res;

endmodule
